// ===== design/assert_macros.svh =====
// Assertion macros used by the table chain engine sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication at every rising edge outside reset.
`define FCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a condition that must hold at every rising edge outside reset.
`define FCT_ALWAYS(label, cond, msg) \
  `FCT_ASSERT(label, (1'b1 |-> (cond)), msg)

`endif

// ===== design/fct_pkg.sv =====
// Types and constants for the FAT12 table chain engine.
package fct_pkg;

  localparam int ENTRY_W = 12;
  localparam int SIZE_W  = 13;
  localparam int LIMIT_W = 7;

  // End-of-chain marker range
  localparam logic [SIZE_W-1:0]  END_LOW   = 13'd4088;
  localparam logic [SIZE_W-1:0]  END_HIGH  = 13'd4095;
  localparam logic [LIMIT_W-1:0] MAX_CHAIN = 7'd64;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_WALK = 2'd1,
    OP_FREE = 2'd2,
    OP_SET  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_RANGE = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef enum logic {
    REG_ENTRIES_IN_USE = 1'b0,
    REG_CHAIN_LIMIT    = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD2,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_WALK_RD,
    S_WALK_CHK,
    S_WALK_OOR
  } state_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [ENTRY_W-1:0]   index;
    logic [23:0]          packed_bytes;
    logic [ENTRY_W-1:0]   entry_value;
  } cmd_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]   value;
    logic [ENTRY_W-1:0]   next_cluster;
    logic                 last;
    status_t              status;
  } result_t;

  // Effective table size and walk limit
  typedef struct packed {
    logic [SIZE_W-1:0]    size;
    logic [LIMIT_W-1:0]   limit;
  } cfg_t;

  typedef struct packed {
    logic                 we;
    logic [ENTRY_W-1:0]   waddr;
    logic [ENTRY_W-1:0]   wdata;
    logic [ENTRY_W-1:0]   raddr;
  } mem_req_t;

endpackage

// ===== design/fct_mem.sv =====
// Allocation table storage: one write port, one registered read port.
module fct_mem
  import fct_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic               clk,
  input  mem_req_t           req,
  output logic [ENTRY_W-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [ENTRY_W-1:0] mem [DEPTH];

  // Write one entry, read one entry each cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.raddr[AW-1:0]];
  end

endmodule

// ===== design/fct_seq.sv =====
// Request sequencer with the shared end-marker and range compare unit.
`include "assert_macros.svh"

module fct_seq
  import fct_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cmd_t               cmd,
  input  cfg_t               cfg,
  input  logic [ENTRY_W-1:0] rdata,
  output logic               busy,
  output logic               done,
  output result_t            result,
  output mem_req_t           mem_req
);

  state_t              state, state_next;
  logic [ENTRY_W-1:0]  cur, cur_next;
  logic [ENTRY_W-1:0]  hold, hold_next;
  logic [LIMIT_W-1:0]  count, count_next;
  logic                done_next;
  result_t             result_next;

  logic                accept;
  logic [SIZE_W-1:0]   e0;
  logic [SIZE_W-1:0]   cur_inc;
  logic [SIZE_W-1:0]   probe;
  logic                probe_end;
  logic                probe_oor;
  logic                load_pair;
  logic [LIMIT_W-1:0]  count_inc;
  logic                at_limit;
  logic                free_hit;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign e0        = {cmd.index, 1'b0};
  assign cur_inc   = {1'b0, cur} + 13'd1;
  assign load_pair = ({cmd.index, 1'b1} != cfg.size);
  assign count_inc = count + 7'd1;
  assign at_limit  = (count_inc >= cfg.limit);
  assign free_hit  = (rdata == '0);

  // Select the operand for the shared compare unit
  always_comb begin
    case (state)
      S_SCAN_CHK: probe = cur_inc;
      S_WALK_CHK: probe = {1'b0, rdata};
      default: begin
        case (cmd.opcode)
          OP_LOAD: probe = e0;
          OP_FREE: probe = '0;
          default: probe = {1'b0, cmd.index};
        endcase
      end
    endcase
  end

  assign probe_end = (probe >= END_LOW) && (probe <= END_HIGH);
  assign probe_oor = (probe >= cfg.size);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.opcode)
            OP_LOAD: if (!probe_oor && load_pair) state_next = S_LOAD2;
            OP_FREE: if (!probe_oor) state_next = S_SCAN_RD;
            OP_WALK: if (!probe_end && !probe_oor) state_next = S_WALK_RD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD2:   state_next = S_IDLE;
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (free_hit || probe_oor) state_next = S_IDLE;
        else state_next = S_SCAN_RD;
      end
      S_WALK_RD: state_next = S_WALK_CHK;
      S_WALK_CHK: begin
        if (probe_end || at_limit) state_next = S_IDLE;
        else if (probe_oor) state_next = S_WALK_OOR;
        else state_next = S_WALK_RD;
      end
      S_WALK_OOR: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Datapath, table port and result word
  always_comb begin
    cur_next            = cur;
    hold_next           = hold;
    count_next          = count;
    done_next           = 1'b0;
    result_next.value        = cur;
    result_next.next_cluster = '0;
    result_next.last         = 1'b1;
    result_next.status       = ST_OK;
    mem_req.we          = 1'b0;
    mem_req.waddr       = cur;
    mem_req.wdata       = hold;
    mem_req.raddr       = cur;
    case (state)
      S_IDLE: begin
        if (accept) begin
          done_next         = 1'b1;
          result_next.value = cmd.index;
          case (cmd.opcode)
            OP_LOAD: begin
              if (probe_oor) begin
                result_next.status = ST_RANGE;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = e0[ENTRY_W-1:0];
                mem_req.wdata = {cmd.packed_bytes[11:8], cmd.packed_bytes[7:0]};
                cur_next      = {cmd.index[ENTRY_W-2:0], 1'b1};
                hold_next     = {cmd.packed_bytes[23:16], cmd.packed_bytes[15:12]};
              end
            end
            OP_SET: begin
              if (probe_oor) begin
                result_next.status = ST_RANGE;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cmd.index;
                mem_req.wdata = cmd.entry_value;
              end
            end
            OP_FREE: begin
              // Empty table reports none; otherwise the scan reports later
              result_next.value  = '0;
              result_next.status = ST_NONE;
              done_next          = probe_oor;
              cur_next           = '0;
            end
            default: begin
              if (probe_end) begin
                result_next.status = ST_NONE;
              end else if (probe_oor) begin
                result_next.status = ST_RANGE;
              end else begin
                done_next = 1'b0;
              end
              cur_next   = cmd.index;
              count_next = '0;
            end
          endcase
        end
      end
      S_LOAD2: begin
        mem_req.we = 1'b1;
      end
      S_SCAN_CHK: begin
        if (free_hit) begin
          done_next = 1'b1;
        end else if (probe_oor) begin
          done_next          = 1'b1;
          result_next.value  = '0;
          result_next.status = ST_NONE;
        end else begin
          cur_next = cur_inc[ENTRY_W-1:0];
        end
      end
      S_WALK_CHK: begin
        done_next = 1'b1;
        if (probe_end) begin
          result_next.status = ST_OK;
        end else if (at_limit) begin
          result_next.next_cluster = rdata;
          result_next.status       = ST_TRUNC;
        end else begin
          result_next.last = 1'b0;
          count_next       = count_inc;
          cur_next         = rdata;
        end
      end
      S_WALK_OOR: begin
        done_next          = 1'b1;
        result_next.status = ST_RANGE;
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      count <= count_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur    <= cur_next;
    hold   <= hold_next;
    result <= result_next;
  end

  `FCT_ASSERT(a_mid_walk_busy, (done && !result.last) |-> busy,
    "non-final word shown while sequencer is idle")
  `FCT_ASSERT(a_mid_walk_ok, (done && !result.last) |-> (result.status == ST_OK),
    "non-final word carries an error status")
  `FCT_ASSERT(a_next_only_trunc, (done && (result.next_cluster != '0)) |->
    (result.status == ST_TRUNC), "next cluster set on a word that is not truncated")
  `FCT_ALWAYS(a_count_bound, count < MAX_CHAIN, "walk member count passed the chain limit")

endmodule

// ===== design/fat12_table_chain_engine.sv =====
// Top level of the FAT12 table chain engine: config registers, table and sequencer.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------
//   command  | start, busy        | cmd (cmd_t)
//   result   | done (one cycle)   | result (result_t)
//   config   | cfg_we             | cfg_index, cfg_data
//
// Load writes one or two table entries (one table write per cycle), set writes one.
// Find free and walk each use a read state and a check state per entry (walk adds a state
// for an out-of-range tail): the single table read port returns registered data.
// Each result word shows on done the cycle after its decision; start is taken when busy is low.
// Reset clears the sequencer and sets entries_in_use to 3072 and chain_limit to 64;
// the table itself is not cleared. The receiver cannot stall.
module fat12_table_chain_engine
  import fct_pkg::*;
#(
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cmd_t                cmd,
  output logic                busy,
  output logic                done,
  output result_t             result,
  input  logic                cfg_we,
  input  reg_index_t          cfg_index,
  input  logic [SIZE_W-1:0]   cfg_data
);

  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_ENTRIES);

  logic [SIZE_W-1:0]  entries_in_use;
  logic [LIMIT_W-1:0] chain_limit;
  cfg_t               cfg;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rdata;

  // Config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= 13'd3072;
      chain_limit    <= MAX_CHAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENTRIES_IN_USE: entries_in_use <= cfg_data;
        REG_CHAIN_LIMIT:    chain_limit    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp size to the table depth and the limit to 1..64
  always_comb begin
    cfg.size = (entries_in_use > MAX_SIZE) ? MAX_SIZE : entries_in_use;
    if (chain_limit == '0) begin
      cfg.limit = 7'd1;
    end else if (chain_limit > MAX_CHAIN) begin
      cfg.limit = MAX_CHAIN;
    end else begin
      cfg.limit = chain_limit;
    end
  end

  fct_mem #(
    .DEPTH (MAX_ENTRIES)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  fct_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .cfg     (cfg),
    .rdata   (rdata),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .mem_req (mem_req)
  );

endmodule

// ===== sim/tb_fat12_table_chain_engine.sv =====
// Self-checking testbench for the FAT12 table chain engine: directed and random commands.
`timescale 1ns / 1ps

module tb_fat12_table_chain_engine;
  import fct_pkg::*;

  localparam int TABLE_DEPTH   = 4096;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1500000;

  // Table mirror, register copy and the queue of result words still owed
  class fat_table_scoreboard;
    logic [ENTRY_W-1:0] fat [TABLE_DEPTH];
    bit                 loaded [TABLE_DEPTH];
    int unsigned        size_reg;
    int unsigned        limit_reg;
    result_t            expected_words [$];
    int                 mismatches;

    function new();
      size_reg   = 3072;
      limit_reg  = 64;
      mismatches = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void set_regs(int unsigned sz, int unsigned lim);
      size_reg  = sz & 32'h1FFF;
      limit_reg = lim & 32'h7F;
    endfunction

    // Clamp the table size to the table depth
    function int unsigned span();
      return (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg;
    endfunction

    function int unsigned walk_cap();
      if (limit_reg == 0) return 1;
      if (limit_reg > MAX_CHAIN) return MAX_CHAIN;
      return limit_reg;
    endfunction

    function bit is_end_marker(int unsigned c);
      return (c >= END_LOW) && (c <= END_HIGH);
    endfunction

    function void store(int unsigned idx, logic [ENTRY_W-1:0] val);
      fat[idx]    = val;
      loaded[idx] = 1'b1;
    endfunction

    function void owe(int unsigned v, int unsigned nxt, bit lst, status_t st);
      result_t w;
      w.value        = v[ENTRY_W-1:0];
      w.next_cluster = nxt[ENTRY_W-1:0];
      w.last         = lst;
      w.status       = st;
      expected_words.insert(expected_words.size(), w);
    endfunction

    // Update the mirror for an accepted command and queue the words it owes
    function void apply_command(cmd_t c);
      int unsigned sz, e0, cur, nxt, n, cap;
      bit          stop;
      sz = span();
      case (c.opcode)
        OP_LOAD: begin
          e0 = {19'd0, c.index, 1'b0};
          if (e0 >= sz) begin
            owe(c.index, 0, 1'b1, ST_RANGE);
          end else begin
            store(e0, c.packed_bytes[11:0]);
            if (e0 + 1 < sz) store(e0 + 1, c.packed_bytes[23:12]);
            owe(c.index, 0, 1'b1, ST_OK);
          end
        end
        OP_SET: begin
          if (c.index >= sz) begin
            owe(c.index, 0, 1'b1, ST_RANGE);
          end else begin
            store(c.index, c.entry_value);
            owe(c.index, 0, 1'b1, ST_OK);
          end
        end
        OP_FREE: begin
          stop = 1'b0;
          for (int unsigned i = 0; i < sz && !stop; i++) begin
            if (fat[i] == '0) begin
              owe(i, 0, 1'b1, ST_OK);
              stop = 1'b1;
            end
          end
          if (!stop) owe(0, 0, 1'b1, ST_NONE);
        end
        default: begin
          cap = walk_cap();
          cur = c.index;
          n   = 0;
          if (is_end_marker(cur)) begin
            owe(cur, 0, 1'b1, ST_NONE);
          end else if (cur >= sz) begin
            owe(cur, 0, 1'b1, ST_RANGE);
          end else begin
            stop = 1'b0;
            while (!stop) begin
              nxt = fat[cur];
              if (is_end_marker(nxt)) begin
                owe(cur, 0, 1'b1, ST_OK);
                stop = 1'b1;
              end else if (n + 1 >= cap) begin
                owe(cur, nxt, 1'b1, ST_TRUNC);
                stop = 1'b1;
              end else begin
                owe(cur, 0, 1'b0, ST_OK);
                n++;
                if (nxt >= sz) begin
                  owe(nxt, 0, 1'b1, ST_RANGE);
                  stop = 1'b1;
                end else begin
                  cur = nxt;
                end
              end
            end
          end
        end
      endcase
    endfunction

    // Compare one result word with the oldest one owed
    function void check_word(result_t r);
      result_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: value %0d status %0d", r.value, r.status);
        mismatches++;
        return;
      end
      w = expected_words.pop_front();
      if (r.value !== w.value) begin
        $error("value: expected %0d, actual %0d", w.value, r.value);
        mismatches++;
      end
      if (r.next_cluster !== w.next_cluster) begin
        $error("next_cluster: expected %0d, actual %0d", w.next_cluster, r.next_cluster);
        mismatches++;
      end
      if (r.last !== w.last) begin
        $error("last: expected %0d, actual %0d", w.last, r.last);
        mismatches++;
      end
      if (r.status !== w.status) begin
        $error("status: expected %0d, actual %0d", w.status, r.status);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  cmd_t              cmd       = '0;
  logic              cfg_we    = 1'b0;
  reg_index_t        cfg_index = REG_ENTRIES_IN_USE;
  logic [SIZE_W-1:0] cfg_data  = '0;
  logic              busy;
  logic              done;
  result_t           result;

  fat_table_scoreboard sb;
  int                  send_idle_pct = 0;
  int unsigned         cycle_count   = 0;

  fat12_table_chain_engine #(.MAX_ENTRIES(TABLE_DEPTH)) DUT (
    .clk,
    .rst,
    .start,
    .cmd,
    .busy,
    .done,
    .result,
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  always #6 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Check every result word on its strobe
  always @(posedge clk) begin
    if (!rst && done) sb.check_word(result);
  end

  function automatic cmd_t make_cmd(opcode_t op, int unsigned idx, int unsigned bytes,
                                    int unsigned val);
    cmd_t c;
    c.opcode       = op;
    c.index        = idx[ENTRY_W-1:0];
    c.packed_bytes = bytes[23:0];
    c.entry_value  = val[ENTRY_W-1:0];
    return c;
  endfunction

  // Pack two entries into the three bytes of one group
  function automatic int unsigned pair_bytes(int unsigned even, int unsigned odd);
    return ((odd & 32'hFFF) << 12) | (even & 32'hFFF);
  endfunction

  // Mostly in-range links, with end markers, free entries and raw values mixed in
  function automatic int unsigned rand_entry(int unsigned sz);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55 && sz > 0) return $urandom_range(sz - 1);
    if (pick < 70) return $urandom_range(int'(END_HIGH), int'(END_LOW));
    if (pick < 80) return 0;
    return $urandom_range(4095);
  endfunction

  // Hold start until the word is taken, after a random idle gap
  task automatic send_cmd(cmd_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.apply_command(c);
  endtask

  // Drop start and wait for every owed word, then a settling gap
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(int unsigned sz, int unsigned lim);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ENTRIES_IN_USE;
    cfg_data  <= sz[SIZE_W-1:0];
    @(posedge clk);
    cfg_index <= REG_CHAIN_LIMIT;
    cfg_data  <= {{(SIZE_W-LIMIT_W){1'b0}}, lim[LIMIT_W-1:0]};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_regs(sz, lim);
    @(posedge clk);
  endtask

  // Load every group that still holds an unwritten entry below the table size
  task automatic fill_table();
    int unsigned sz;
    sz = sb.span();
    for (int unsigned g = 0; 2 * g < sz; g++) begin
      if (!sb.loaded[2 * g] || (2 * g + 1 < sz && !sb.loaded[2 * g + 1]))
        send_cmd(make_cmd(OP_LOAD, g, pair_bytes(rand_entry(sz), rand_entry(sz)), 0));
    end
  endtask

  task automatic random_item();
    int unsigned sz, pick, idx, bytes;
    sz   = sb.span();
    pick = $urandom_range(99);
    if (pick < 20) begin
      idx   = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range((sz + 1) / 2 - 1);
      bytes = $urandom_range(1) ? pair_bytes(rand_entry(sz), rand_entry(sz))
                                : ($urandom() & 32'hFFFFFF);
      send_cmd(make_cmd(OP_LOAD, idx, bytes, $urandom_range(4095)));
    end else if (pick < 45) begin
      idx = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(sz - 1);
      send_cmd(make_cmd(OP_SET, idx, $urandom() & 32'hFFFFFF, rand_entry(sz)));
    end else if (pick < 85) begin
      pick = $urandom_range(99);
      if (pick < 10) idx = $urandom_range(4095);
      else if (pick < 15) idx = $urandom_range(int'(END_HIGH), int'(END_LOW));
      else idx = $urandom_range(sz - 1);
      send_cmd(make_cmd(OP_WALK, idx, $urandom() & 32'hFFFFFF, $urandom_range(4095)));
    end else begin
      send_cmd(make_cmd(OP_FREE, $urandom_range(4095), $urandom() & 32'hFFFFFF,
                        $urandom_range(4095)));
    end
  endtask

  task automatic run_segment(int unsigned sz, int unsigned lim, int count);
    write_cfg(sz, lim);
    fill_table();
    repeat (count) random_item();
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Table size after reset: last entry in range, next one out
    send_cmd(make_cmd(OP_SET, 3071, 0, 12'hFFF));
    send_cmd(make_cmd(OP_SET, 3072, 0, 1));

    // Odd table size: last group writes its even entry only
    write_cfg(9, 3);
    send_cmd(make_cmd(OP_LOAD, 0, pair_bytes(0, 2), 0));
    send_cmd(make_cmd(OP_LOAD, 1, pair_bytes(3, 12'hFFF), 0));
    send_cmd(make_cmd(OP_LOAD, 2, pair_bytes(5, 6), 0));
    send_cmd(make_cmd(OP_LOAD, 3, pair_bytes(4, 12'h100), 0));
    send_cmd(make_cmd(OP_LOAD, 4, pair_bytes(12'hFF8, 12'hABC), 0));
    send_cmd(make_cmd(OP_LOAD, 5, 24'h123456, 0));
    send_cmd(make_cmd(OP_LOAD, 4095, 24'hFFFFFF, 0));
    send_cmd(make_cmd(OP_FREE, 0, 0, 0));

    // Chain to an end marker, a loop cut at the limit, a link out of range,
    // a single member, starts on end markers and a start out of range
    send_cmd(make_cmd(OP_WALK, 1, 0, 0));
    send_cmd(make_cmd(OP_WALK, 4, 0, 0));
    send_cmd(make_cmd(OP_WALK, 7, 0, 0));
    send_cmd(make_cmd(OP_WALK, 8, 0, 0));
    send_cmd(make_cmd(OP_WALK, END_LOW, 0, 0));
    send_cmd(make_cmd(OP_WALK, END_HIGH, 0, 0));
    send_cmd(make_cmd(OP_WALK, 9, 0, 0));

    // No free entry left; sets out of range
    send_cmd(make_cmd(OP_SET, 0, 0, 12'hFFF));
    send_cmd(make_cmd(OP_SET, 9, 0, 5));
    send_cmd(make_cmd(OP_SET, 4095, 0, 0));
    send_cmd(make_cmd(OP_FREE, 0, 0, 0));
    send_cmd(make_cmd(OP_WALK, 0, 0, 0));

    // Chain limit zero acts as one, above the maximum as the maximum
    write_cfg(9, 0);
    send_cmd(make_cmd(OP_WALK, 4, 0, 0));
    write_cfg(9, 127);
    send_cmd(make_cmd(OP_WALK, 4, 0, 0));

    // Empty table and a table of one entry
    write_cfg(0, 1);
    send_cmd(make_cmd(OP_FREE, 0, 0, 0));
    send_cmd(make_cmd(OP_WALK, 0, 0, 0));
    send_cmd(make_cmd(OP_LOAD, 0, 24'hFFFFFF, 0));
    write_cfg(1, 64);
    send_cmd(make_cmd(OP_FREE, 0, 0, 0));
    send_cmd(make_cmd(OP_WALK, 0, 0, 0));

    // Random commands over several table sizes and chain limits
    send_idle_pct = 16;
    run_segment(16, 64, 22);
    run_segment(2, 1, 22);
    run_segment(40, 127, 22);
    run_segment(130, 64, 22);
    send_idle_pct = 67;
    run_segment(64, 0, 22);
    run_segment(5, 5, 22);
    run_segment(100, 20, 22);
    run_segment(48, 64, 22);
    send_idle_pct = 0;
    run_segment(30, 64, 22);
    run_segment(3, 2, 22);
    run_segment(150, 40, 22);
    run_segment(160, 64, 22);

    settle();
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/fct_pkg.sv
design/fct_mem.sv
design/fct_seq.sv
design/fat12_table_chain_engine.sv
sim/tb_fat12_table_chain_engine.sv
